/* design/rhcl_pkg.sv */
// ----------------------------------------------------------------------------
// rhcl_pkg
// Shared widths, constants and types for the RGB to hue/chroma/lightness
// pipeline.
// ----------------------------------------------------------------------------
package rhcl_pkg;

  localparam int HUE_FRAC_BITS_DEF = 6;    // default hue fraction bits
  localparam int CH_W     = 8;             // pixel channel width
  localparam int LT_W     = CH_W + 1;      // max + min
  localparam int HUE_W    = 15;            // hue result width
  localparam int NUM_W    = 11;            // sector numerator, below 6*255
  localparam int SCALE_W  = NUM_W + 6;     // numerator times 60
  localparam int DEG_INT_W = 9;            // integer bits of a hue below 360
  localparam int QSTEP    = 2;             // quotient bits per divider stage

  localparam int DEG_SECTOR = 60;
  localparam int DEG_FULL   = 360;

  // sector offsets in units of chroma
  localparam int SEC_GREEN = 2;
  localparam int SEC_BLUE  = 4;
  localparam int SEC_WRAP  = 6;

  // fields that ride along the divider untouched
  typedef struct packed {
    logic [CH_W-1:0] chroma;
    logic [CH_W-1:0] value;
    logic [LT_W-1:0] lightness_twice;
    logic            achromatic;
  } side_t;

endpackage

/* design/rhcl_prep.sv */
// ----------------------------------------------------------------------------
// rhcl_prep
// First stage: max, min, chroma, lightness and the hue sector numerator.
// ----------------------------------------------------------------------------
module rhcl_prep (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [rhcl_pkg::CH_W-1:0] red,
  input  logic [rhcl_pkg::CH_W-1:0] green,
  input  logic [rhcl_pkg::CH_W-1:0] blue,
  output logic                      vld_r,
  output logic [rhcl_pkg::NUM_W-1:0] num_r,
  output logic [rhcl_pkg::CH_W-1:0] div_r,
  output rhcl_pkg::side_t           side_r
);

  logic [rhcl_pkg::CH_W-1:0]  mx, mn, c;
  logic [rhcl_pkg::NUM_W-1:0] cw, rw, gw, bw;
  logic [rhcl_pkg::NUM_W-1:0] num_nxt;
  logic [rhcl_pkg::CH_W-1:0]  div_nxt;
  rhcl_pkg::side_t            side_nxt;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    c = mx - mn;

    cw = rhcl_pkg::NUM_W'(c);
    rw = rhcl_pkg::NUM_W'(red);
    gw = rhcl_pkg::NUM_W'(green);
    bw = rhcl_pkg::NUM_W'(blue);

    // every numerator is non-negative, so modular math is exact
    if (red == mx) begin
      if (green >= blue) num_nxt = gw - bw;
      else num_nxt = rhcl_pkg::NUM_W'(rhcl_pkg::SEC_WRAP) * cw + gw - bw;
    end else if (green == mx) begin
      num_nxt = rhcl_pkg::NUM_W'(rhcl_pkg::SEC_GREEN) * cw + bw - rw;
    end else begin
      num_nxt = rhcl_pkg::NUM_W'(rhcl_pkg::SEC_BLUE) * cw + rw - gw;
    end

    // gray: numerator is zero, divide by one to get hue 0
    div_nxt = (c == '0) ? rhcl_pkg::CH_W'(1) : c;

    side_nxt.chroma          = c;
    side_nxt.value           = mx;
    side_nxt.lightness_twice = rhcl_pkg::LT_W'(mx) + rhcl_pkg::LT_W'(mn);
    side_nxt.achromatic      = (c == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_nxt;
      div_r  <= div_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

/* design/rhcl_scale.sv */
// ----------------------------------------------------------------------------
// rhcl_scale
// Second stage: dividend = numerator * 60 << frac, split into the starting
// partial remainder and the bits still to be shifted in.
// ----------------------------------------------------------------------------
module rhcl_scale #(
  parameter int HUE_FRAC_BITS = rhcl_pkg::HUE_FRAC_BITS_DEF,
  parameter int QP            = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [rhcl_pkg::NUM_W-1:0] num,
  input  logic [rhcl_pkg::CH_W-1:0]  div,
  input  rhcl_pkg::side_t            side,
  output logic                       vld_r,
  output logic [rhcl_pkg::CH_W-1:0]  rem_r,
  output logic [QP-1:0]              bits_r,
  output logic [rhcl_pkg::CH_W-1:0]  div_r,
  output rhcl_pkg::side_t            side_r
);

  localparam int N_W = rhcl_pkg::SCALE_W + HUE_FRAC_BITS;

  logic [rhcl_pkg::SCALE_W-1:0] prod;
  logic [N_W-1:0]               dividend;

  // dividend < 2^QP * div, so the top part is already below the divisor
  always_comb begin
    prod     = rhcl_pkg::SCALE_W'(num) * rhcl_pkg::SCALE_W'(rhcl_pkg::DEG_SECTOR);
    dividend = N_W'(prod) << HUE_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rhcl_pkg::CH_W'(dividend >> QP);
      bits_r <= dividend[QP-1:0];
      div_r  <= div;
      side_r <= side;
    end
  end

endmodule

/* design/rhcl_div_stage.sv */
// ----------------------------------------------------------------------------
// rhcl_div_stage
// One restoring divider stage: QSTEP quotient bits per clock while en is high.
// ----------------------------------------------------------------------------
module rhcl_div_stage #(
  parameter int QP = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [rhcl_pkg::CH_W-1:0] rem,
  input  logic [QP-1:0]             bits,
  input  logic [QP-1:0]             quo,
  input  logic [rhcl_pkg::CH_W-1:0] div,
  input  rhcl_pkg::side_t           side,
  output logic                      vld_r,
  output logic [rhcl_pkg::CH_W-1:0] rem_r,
  output logic [QP-1:0]             bits_r,
  output logic [QP-1:0]             quo_r,
  output logic [rhcl_pkg::CH_W-1:0] div_r,
  output rhcl_pkg::side_t           side_r
);

  logic [rhcl_pkg::CH_W-1:0] r;
  logic [rhcl_pkg::CH_W:0]   t;
  logic [QP-1:0]             b, q;

  always_comb begin
    r = rem;
    b = bits;
    q = quo;
    t = '0;
    for (int i = 0; i < rhcl_pkg::QSTEP; i++) begin
      t = {r, b[QP-1]};
      b = b << 1;
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
        q = {q[QP-2:0], 1'b1};
      end else begin
        q = {q[QP-2:0], 1'b0};
      end
      r = t[rhcl_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= r;
      bits_r <= b;
      quo_r  <= q;
      div_r  <= div;
      side_r <= side;
    end
  end

endmodule

/* design/rgb_to_hue_chroma_lightness.sv */
// ----------------------------------------------------------------------------
// rgb_to_hue_chroma_lightness
// 8-bit RGB pixel to hue (fixed point degrees), chroma, value and twice the
// lightness, one pixel per clock while the input is not stalled.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_stall is low, returns one result beat
// per pixel, in order. Stage one finds max/min, chroma, lightness and the hue
// sector numerator; stage two scales it by 60 and by 2^HUE_FRAC_BITS; the
// remaining stages are a pipelined restoring divider by chroma that retires
// two quotient bits per stage, so the divider's stage count sets the latency.
// Hue is truncated toward zero and masked to 15 bits. Gray pixels give hue 0
// with achromatic set. A stall on the result side freezes only the occupied
// stages with no empty stage after them; the rest keep moving, so input is
// taken while a result waits until every stage is full.
// ----------------------------------------------------------------------------
module rgb_to_hue_chroma_lightness #(
  parameter int HUE_FRAC_BITS = rhcl_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rhcl_pkg::CH_W-1:0]   in_red,
  input  logic [rhcl_pkg::CH_W-1:0]   in_green,
  input  logic [rhcl_pkg::CH_W-1:0]   in_blue,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rhcl_pkg::HUE_W-1:0]  out_hue,
  output logic [rhcl_pkg::CH_W-1:0]   out_chroma,
  output logic [rhcl_pkg::CH_W-1:0]   out_value,
  output logic [rhcl_pkg::LT_W-1:0]   out_lightness_twice,
  output logic                        out_achromatic
);

  // quotient bits needed, padded to a whole number of divider stages
  localparam int QW = rhcl_pkg::DEG_INT_W + HUE_FRAC_BITS;
  localparam int NS = (QW + rhcl_pkg::QSTEP - 1) / rhcl_pkg::QSTEP;
  localparam int QP = NS * rhcl_pkg::QSTEP;
  localparam int LAST = NS + 1;        // index of the output stage

  // per-stage valid and load enable: 0 prep, 1 scale, 2.. divider
  logic vld [LAST+1];
  logic en  [LAST+1];

  // prep -> scale
  logic [rhcl_pkg::NUM_W-1:0] p_num;
  logic [rhcl_pkg::CH_W-1:0]  p_div;
  rhcl_pkg::side_t            p_side;

  // divider chain, index 0 is the scale stage output
  logic [rhcl_pkg::CH_W-1:0]  d_rem  [NS+1];
  logic [QP-1:0]              d_bits [NS+1];
  logic [QP-1:0]              d_quo  [NS+1];
  logic [rhcl_pkg::CH_W-1:0]  d_div  [NS+1];
  rhcl_pkg::side_t            d_side [NS+1];

  // a stage loads when empty or when the next one loads
  assign en[LAST] = !vld[LAST] || !out_stall;
  for (genvar k = 0; k < LAST; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_stall = !en[0];

  rhcl_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[0]),
    .in_vld (in_valid),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .vld_r  (vld[0]),
    .num_r  (p_num),
    .div_r  (p_div),
    .side_r (p_side)
  );

  rhcl_scale #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .QP            (QP)
  ) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[1]),
    .in_vld (vld[0]),
    .num    (p_num),
    .div    (p_div),
    .side   (p_side),
    .vld_r  (vld[1]),
    .rem_r  (d_rem[0]),
    .bits_r (d_bits[0]),
    .div_r  (d_div[0]),
    .side_r (d_side[0])
  );

  // quotient starts empty
  assign d_quo[0] = '0;

  for (genvar s = 0; s < NS; s++) begin : g_div
    rhcl_div_stage #(
      .QP (QP)
    ) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en[s+2]),
      .in_vld (vld[s+1]),
      .rem    (d_rem[s]),
      .bits   (d_bits[s]),
      .quo    (d_quo[s]),
      .div    (d_div[s]),
      .side   (d_side[s]),
      .vld_r  (vld[s+2]),
      .rem_r  (d_rem[s+1]),
      .bits_r (d_bits[s+1]),
      .quo_r  (d_quo[s+1]),
      .div_r  (d_div[s+1]),
      .side_r (d_side[s+1])
    );
  end

  // last divider stage is the output register
  assign out_valid           = vld[LAST];
  assign out_hue             = rhcl_pkg::HUE_W'(d_quo[NS]);
  assign out_chroma          = d_side[NS].chroma;
  assign out_value           = d_side[NS].value;
  assign out_lightness_twice = d_side[NS].lightness_twice;
  assign out_achromatic      = d_side[NS].achromatic;

`ifndef ASSERT_OFF
  // gray pixels must come out with zero hue
  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_achromatic |-> out_hue == '0)
    else $error("gray pixel with nonzero hue");

  // flag tracks chroma through the pipe
  a_gray_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_achromatic == (out_chroma == '0))
    else $error("achromatic flag out of step with chroma");

  // chroma, value and lightness belong to the same pixel
  a_side_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rhcl_pkg::LT_W'(out_value) + rhcl_pkg::LT_W'(out_value)
                   - out_lightness_twice) == rhcl_pkg::LT_W'(out_chroma))
    else $error("side fields of one beat disagree");

  // hue stays below a full turn when it fits the port
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (QW <= rhcl_pkg::HUE_W) |->
      32'(out_hue) < (rhcl_pkg::DEG_FULL << HUE_FRAC_BITS))
    else $error("hue at or above 360 degrees");

  // an empty output stage never holds back the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output stage");
`endif

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_to_hue_chroma_lightness: directed corner
// pixels, a back-pressure burst and about 1200 random pixels.
// ----------------------------------------------------------------------------
// Every pixel beat taken by the block is converted by a predictor in the
// scoreboard class and queued. Each result beat is checked field by field
// against the oldest queued color. Both sides idle at random, and the result
// side also holds off long enough that the pipeline fills and stalls input.
// ----------------------------------------------------------------------------

typedef struct {
  logic [rhcl_pkg::HUE_W-1:0] hue;
  logic [rhcl_pkg::CH_W-1:0]  chroma;
  logic [rhcl_pkg::CH_W-1:0]  value;
  logic [rhcl_pkg::LT_W-1:0]  lightness_twice;
  logic                       achromatic;
} hcl_color_t;

class hue_scoreboard;
  hcl_color_t  pending_colors[$];
  int unsigned failures;

  function new();
    failures = 0;
  endfunction

  // Hue is one exact rational: 60 * 2^frac * num / chroma, floored.
  function hcl_color_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hcl_color_t       col;
    int unsigned      mx;
    int unsigned      mn;
    int unsigned      c;
    int unsigned      num;
    longint unsigned  scaled;
    longint unsigned  quot;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    quot = 0;
    if (c != 0) begin
      if (r == mx) begin
        // red sector wraps negative angles up by a full turn
        if (g >= b) num = g - b;
        else num = rhcl_pkg::SEC_WRAP * c + g - b;
      end else if (g == mx) begin
        num = rhcl_pkg::SEC_GREEN * c + b - r;
      end else begin
        num = rhcl_pkg::SEC_BLUE * c + r - g;
      end
      scaled = (longint'(num) * rhcl_pkg::DEG_SECTOR) << rhcl_pkg::HUE_FRAC_BITS_DEF;
      quot = scaled / c;
    end
    col.hue             = quot[rhcl_pkg::HUE_W-1:0];
    col.chroma          = c[7:0];
    col.value           = mx[7:0];
    col.lightness_twice = rhcl_pkg::LT_W'(mx + mn);
    col.achromatic      = (c == 0);
    return col;
  endfunction

  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pending_colors.push_back(convert_pixel(r, g, b));
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function void check_result(logic [rhcl_pkg::HUE_W-1:0] hue,
                             logic [rhcl_pkg::CH_W-1:0] chroma,
                             logic [rhcl_pkg::CH_W-1:0] value,
                             logic [rhcl_pkg::LT_W-1:0] lightness_twice,
                             logic achromatic);
    hcl_color_t want;
    if (pending_colors.size() == 0) begin
      $error("result beat with no pixel outstanding (hue %0d)", hue);
      failures++;
      return;
    end
    want = pending_colors.pop_front();
    check_field("hue", want.hue, hue);
    check_field("chroma", want.chroma, chroma);
    check_field("value", want.value, value);
    check_field("lightness_twice", want.lightness_twice, lightness_twice);
    check_field("achromatic", want.achromatic, achromatic);
  endfunction

  function int unsigned outstanding();
    return pending_colors.size();
  endfunction
endclass

module testbench;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [rhcl_pkg::CH_W-1:0]   in_red;
  logic [rhcl_pkg::CH_W-1:0]   in_green;
  logic [rhcl_pkg::CH_W-1:0]   in_blue;
  logic                        out_valid;
  logic                        out_stall;
  logic [rhcl_pkg::HUE_W-1:0]  out_hue;
  logic [rhcl_pkg::CH_W-1:0]   out_chroma;
  logic [rhcl_pkg::CH_W-1:0]   out_value;
  logic [rhcl_pkg::LT_W-1:0]   out_lightness_twice;
  logic                        out_achromatic;

  hue_scoreboard sb = new();

  // sender idles between beats while tx_idle is set; cleared for bursts
  bit          tx_idle = 1'b1;
  // a nonzero value asks the receiver to hold off; the value sets how long
  int unsigned long_hold_cycles = 0;

  rgb_to_hue_chroma_lightness u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hue             (out_hue),
    .out_chroma          (out_chroma),
    .out_value           (out_value),
    .out_lightness_twice (out_lightness_twice),
    .out_achromatic      (out_achromatic)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one pixel beat. Called just after a falling edge and returns just
  // after the falling edge that follows acceptance, so valid stays high
  // across back-to-back beats without a glitch.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_red   = r;
    in_green = g;
    in_blue  = b;
    // stall is read before the edge's updates land, i.e. as the block saw it
    do @(posedge clk); while (in_stall);
    sb.note_pixel(r, g, b);
    @(negedge clk);
  endtask

  // sender pause: wait for the pipeline to empty out completely
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Result monitor: a beat moves when valid is high and stall is low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_hue, out_chroma, out_value, out_lightness_twice, out_achromatic);
  end

  // Receiver: draws a stall count per beat, flips between idling and
  // streaming now and then, and serves long hold-off requests.
  initial begin : receiver
    int unsigned hold;
    bit          rx_idle;
    rx_idle   = 1'b1;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_cycles != 0) begin
        out_stall = 1'b1;
        repeat (long_hold_cycles) @(negedge clk);
        long_hold_cycles = 0;
      end else begin
        hold = rx_idle ? $urandom_range(0, 18) : 0;
        if (hold != 0) begin
          out_stall = 1'b1;
          repeat (hold) @(negedge clk);
        end
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid && long_hold_cycles == 0);
      @(negedge clk);
      if ($urandom_range(0, 29) == 0) rx_idle = !rx_idle;
    end
  end

  initial begin : stimulus
    logic [7:0] corner [0:21][0:2];
    logic [7:0] r, g, b, top, low;
    int unsigned kind;
    int unsigned i;

    // black, white, gray and pure primaries
    corner[0]  = '{8'd0,   8'd0,   8'd0};
    corner[1]  = '{8'd255, 8'd255, 8'd255};
    corner[2]  = '{8'd128, 8'd128, 8'd128};
    corner[3]  = '{8'd255, 8'd0,   8'd0};
    corner[4]  = '{8'd0,   8'd255, 8'd0};
    corner[5]  = '{8'd0,   8'd0,   8'd255};
    // max ties (the secondaries): red beats green, green beats blue, red beats blue
    corner[6]  = '{8'd255, 8'd255, 8'd0};
    corner[7]  = '{8'd0,   8'd255, 8'd255};
    corner[8]  = '{8'd255, 8'd0,   8'd255};
    // red sector wrap, just below a full turn and just above zero
    corner[9]  = '{8'd255, 8'd0,   8'd1};
    corner[10] = '{8'd255, 8'd1,   8'd0};
    // smallest chroma in each sector, including the wrap
    corner[11] = '{8'd1,   8'd0,   8'd0};
    corner[12] = '{8'd0,   8'd1,   8'd0};
    corner[13] = '{8'd0,   8'd0,   8'd1};
    corner[14] = '{8'd1,   8'd0,   8'd1};
    corner[15] = '{8'd255, 8'd254, 8'd255};
    // near-ties at the sector borders, then three mixed colors
    corner[16] = '{8'd254, 8'd255, 8'd0};
    corner[17] = '{8'd0,   8'd254, 8'd255};
    corner[18] = '{8'd255, 8'd0,   8'd254};
    corner[19] = '{8'd170, 8'd85,  8'd85};
    corner[20] = '{8'd1,   8'd254, 8'd127};
    corner[21] = '{8'd128, 8'd127, 8'd129};

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_red   = '0;
    in_green = '0;
    in_blue  = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < 22; i++) send_pixel(corner[i][0], corner[i][1], corner[i][2]);
    drain_results();

    // back-pressure: receiver blocks while pixels keep coming back to back,
    // so the pipeline fills and the block must stall its input
    long_hold_cycles = 150;
    tx_idle = 1'b0;
    for (i = 0; i < 40; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    tx_idle = 1'b1;
    drain_results();

    for (i = 0; i < 1200; i++) begin
      kind = $urandom_range(0, 9);
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case (kind)
        5: begin
          // gray
          g = r;
          b = r;
        end
        6: begin
          // two channels share the max, the third is lower
          top = 8'($urandom_range(1, 255));
          low = 8'($urandom_range(0, top - 1));
          case ($urandom_range(0, 2))
            0: begin r = top; g = top; b = low; end
            1: begin r = top; g = low; b = top; end
            default: begin r = low; g = top; b = top; end
          endcase
        end
        7: begin
          // small chroma: channels within a few codes of each other
          top = 8'($urandom_range(0, 252));
          r = 8'(top + $urandom_range(0, 3));
          g = 8'(top + $urandom_range(0, 3));
          b = 8'(top + $urandom_range(0, 3));
        end
        8: begin
          // extreme codes only
          r = 8'(($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ $urandom_range(0, 1));
          g = 8'(($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ $urandom_range(0, 1));
          b = 8'(($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ $urandom_range(0, 1));
        end
        default: ;
      endcase
      send_pixel(r, g, b);
      // switch between idling and streaming stretches on the send side
      if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 299) == 0) drain_results();
    end

    drain_results();
    repeat (30) @(negedge clk);
    if (sb.failures == 0) begin
      $display("rgb_to_hue_chroma_lightness verification clean");
    end else begin
      $display("rgb_to_hue_chroma_lightness verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("rgb_to_hue_chroma_lightness verification failed");
    $finish;
  end

endmodule

/* filelist.f */
design/rhcl_pkg.sv
design/rhcl_prep.sv
design/rhcl_scale.sv
design/rhcl_div_stage.sv
design/rgb_to_hue_chroma_lightness.sv
tb/testbench.sv
